/* src/utv_pkg.sv */
// Shared types, codes and byte constants for the UTF-8 text validator.
package utv_pkg;

	// Verdict reason codes
	localparam logic [2:0] REASON_OK    = 3'd0;
	localparam logic [2:0] REASON_EMPTY = 3'd1;
	localparam logic [2:0] REASON_LONG  = 3'd2;
	localparam logic [2:0] REASON_BAD   = 3'd3;
	localparam logic [2:0] REASON_CTRL  = 3'd4;

	// Bound on the next continuation byte
	localparam logic [2:0] RULE_NONE    = 3'd0;
	localparam logic [2:0] RULE_GE_A0   = 3'd1;
	localparam logic [2:0] RULE_LT_A0   = 3'd2;
	localparam logic [2:0] RULE_GE_90   = 3'd3;
	localparam logic [2:0] RULE_LT_90   = 3'd4;

	localparam int unsigned CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_SAT = 17'h1FFFF;

	localparam int unsigned CFG_W = 16;
	localparam logic [CFG_W-1:0] CFG_RST = 16'd4096;

	localparam logic [7:0] B_TAB      = 8'h09;
	localparam logic [7:0] B_LF       = 8'h0A;
	localparam logic [7:0] B_SPACE    = 8'h20;
	localparam logic [7:0] B_ASCII_HI = 8'h7F;
	localparam logic [7:0] B_CONT_MSK = 8'hC0;
	localparam logic [7:0] B_CONT_TAG = 8'h80;
	localparam logic [7:0] B_L2_LO    = 8'hC2;
	localparam logic [7:0] B_L2_HI    = 8'hDF;
	localparam logic [7:0] B_L3_LO    = 8'hE0;
	localparam logic [7:0] B_L3_HI    = 8'hEF;
	localparam logic [7:0] B_SURR     = 8'hED;
	localparam logic [7:0] B_L4_LO    = 8'hF0;
	localparam logic [7:0] B_L4_HI    = 8'hF4;
	localparam logic [7:0] B_A0       = 8'hA0;
	localparam logic [7:0] B_90       = 8'h90;

	// Per-message decoder state
	typedef struct packed {
		logic [1:0] pending;
		logic [2:0] rule;
		logic       enc_err;
		logic       ctrl_seen;
	} msg_state_t;

endpackage

/* src/utv_step.sv */
// Next-state logic of the UTF-8 decoder for one message byte.
module utv_step (
	input  utv_pkg::msg_state_t cur,
	input  logic [7:0]          data_byte,
	input  logic                has_byte,
	output utv_pkg::msg_state_t nxt
);

	logic is_ctrl;
	logic bad_cont;

	assign is_ctrl = (data_byte < utv_pkg::B_SPACE) && (data_byte != utv_pkg::B_TAB)
		&& (data_byte != utv_pkg::B_LF);

	always_comb begin
		bad_cont = (data_byte & utv_pkg::B_CONT_MSK) != utv_pkg::B_CONT_TAG;
		case (cur.rule)
			utv_pkg::RULE_GE_A0: bad_cont = bad_cont || (data_byte < utv_pkg::B_A0);
			utv_pkg::RULE_LT_A0: bad_cont = bad_cont || (data_byte >= utv_pkg::B_A0);
			utv_pkg::RULE_GE_90: bad_cont = bad_cont || (data_byte < utv_pkg::B_90);
			utv_pkg::RULE_LT_90: bad_cont = bad_cont || (data_byte >= utv_pkg::B_90);
			default: ;
		endcase
	end

	always_comb begin
		nxt = cur;
		if (has_byte) begin
			if (is_ctrl)
				nxt.ctrl_seen = 1'b1;
			if (cur.pending != 2'd0) begin
				nxt.rule = utv_pkg::RULE_NONE;
				if (bad_cont) begin
					nxt.enc_err = 1'b1;
					nxt.pending = 2'd0;
				end else begin
					nxt.pending = cur.pending - 2'd1;
				end
			end else if (data_byte <= utv_pkg::B_ASCII_HI) begin
				// plain ASCII: nothing to track
			end else if (data_byte >= utv_pkg::B_L2_LO && data_byte <= utv_pkg::B_L2_HI) begin
				nxt.pending = 2'd1;
				nxt.rule    = utv_pkg::RULE_NONE;
			end else if (data_byte >= utv_pkg::B_L3_LO && data_byte <= utv_pkg::B_L3_HI) begin
				nxt.pending = 2'd2;
				if (data_byte == utv_pkg::B_L3_LO)
					nxt.rule = utv_pkg::RULE_GE_A0;
				else if (data_byte == utv_pkg::B_SURR)
					nxt.rule = utv_pkg::RULE_LT_A0;
				else
					nxt.rule = utv_pkg::RULE_NONE;
			end else if (data_byte >= utv_pkg::B_L4_LO && data_byte <= utv_pkg::B_L4_HI) begin
				nxt.pending = 2'd3;
				if (data_byte == utv_pkg::B_L4_LO)
					nxt.rule = utv_pkg::RULE_GE_90;
				else if (data_byte == utv_pkg::B_L4_HI)
					nxt.rule = utv_pkg::RULE_LT_90;
				else
					nxt.rule = utv_pkg::RULE_NONE;
			end else begin
				nxt.enc_err = 1'b1;
			end
		end
	end

endmodule

/* src/utf8_text_validator.sv */
// Top level of the streaming UTF-8 text validator with length limit.
//
// Channel   Direction  Handshake          Beat contents
// in        sink       in_valid/in_stall  data_byte, has_byte, last
// out       source     out_valid/out_stall done_res, accepted, reason
// cfg       sink       max_bytes_we       max_bytes (16 bit limit)
//
// One beat in, one beat out; a new beat is taken every cycle when out is not stalled.
// Two registers lie on the path: the input register, then decode and verdict into the result register.
// The per-byte decode plus one 17-bit compare against the limit sets the cycle time.
// Reset clears message state and both valid flags; limit loads min(4096, LIMIT_MAX).
// A stall on out holds the result register and, if a beat waits in the input
// register, stalls in as well; otherwise in keeps flowing into the input register.
module utf8_text_validator #(
	parameter int unsigned LIMIT_MAX = 65535
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       max_bytes_we,
	input  logic [utv_pkg::CFG_W-1:0]  max_bytes,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       has_byte,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       done_res,
	output logic                       accepted,
	output logic [2:0]                 reason
);

	// Effective limit never exceeds the 16-bit register range
	localparam int unsigned LIM_CAP = (LIMIT_MAX < 65535) ? LIMIT_MAX : 65535;
	localparam int unsigned LIM_W   = $clog2(LIM_CAP + 1);
	localparam int unsigned LIM_RST = (LIM_CAP < 4096) ? LIM_CAP : 4096;

	logic [LIM_W-1:0]          limit_q;

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      has_s1;
	logic                      last_s1;

	utv_pkg::msg_state_t       st_q;
	utv_pkg::msg_state_t       st_nxt;
	logic [utv_pkg::CNT_W-1:0] count_q;
	logic [utv_pkg::CNT_W-1:0] count_nxt;

	logic                      out_valid_q;
	logic                      done_q;
	logic                      acc_q;
	logic [2:0]                reason_q;

	logic                      advance;
	logic [2:0]                reason_nxt;

	// Clamp the limit when it is written so the verdict path only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_W'(LIM_RST);
		end else if (max_bytes_we) begin
			if (max_bytes > 16'(LIM_CAP))
				limit_q <= LIM_W'(LIM_CAP);
			else
				limit_q <= LIM_W'(max_bytes);
		end
	end

	// Result register moves when it is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			has_s1  <= has_byte;
			last_s1 <= last;
		end
	end

	utv_step u_step (
		.cur       (st_q),
		.data_byte (byte_s1),
		.has_byte  (has_s1),
		.nxt       (st_nxt)
	);

	// Saturating byte count
	assign count_nxt = (has_s1 && count_q != utv_pkg::CNT_SAT) ? count_q + 1'b1 : count_q;

	// Verdict with priority empty, too long, bad encoding, control byte
	always_comb begin
		if (count_nxt == '0)
			reason_nxt = utv_pkg::REASON_EMPTY;
		else if (count_nxt > utv_pkg::CNT_W'(limit_q))
			reason_nxt = utv_pkg::REASON_LONG;
		else if (st_nxt.enc_err || st_nxt.pending != 2'd0)
			reason_nxt = utv_pkg::REASON_BAD;
		else if (st_nxt.ctrl_seen)
			reason_nxt = utv_pkg::REASON_CTRL;
		else
			reason_nxt = utv_pkg::REASON_OK;
	end

	// Message state: advance on every beat, drop everything after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			count_q <= '0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				st_q    <= '0;
				count_q <= '0;
			end else begin
				st_q    <= st_nxt;
				count_q <= count_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			done_q   <= last_s1;
			acc_q    <= last_s1 && (reason_nxt == utv_pkg::REASON_OK);
			reason_q <= last_s1 ? reason_nxt : utv_pkg::REASON_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign done_res  = done_q;
	assign accepted  = acc_q;
	assign reason    = reason_q;

	// A verdict accepts exactly when its reason is clean
	a_acc_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> acc_q == (reason_q == utv_pkg::REASON_OK))
		else $error("accepted disagrees with reason");

	// A mid-message beat carries no verdict
	a_idle_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> !acc_q && reason_q == utv_pkg::REASON_OK)
		else $error("non-final beat carries a verdict");

	// The last beat of a message leaves the decoder empty
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && last_s1 |=> count_q == '0 && st_q == '0)
		else $error("message state not cleared after last beat");

	// Stall in only while a beat waits in the input register
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room to move");

endmodule

/* test/tb_utf8_text_validator.sv */
// Self-checking testbench for the streaming UTF-8 text validator.
`timescale 1ns / 1ps

module tb_utf8_text_validator;

	// One expected result beat
	typedef struct packed {
		logic       done;
		logic       ok;
		logic [2:0] why;
	} verdict_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      max_bytes_we = 1'b0;
	logic [utv_pkg::CFG_W-1:0] max_bytes = utv_pkg::CFG_RST;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [7:0]                data_byte = 8'h00;
	logic                      has_byte = 1'b0;
	logic                      last = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      done_res;
	logic                      accepted;
	logic [2:0]                reason;

	// Mirror of the block's message state and limit
	logic [1:0]                dec_pending = 2'd0;
	logic [2:0]                dec_rule = utv_pkg::RULE_NONE;
	logic [utv_pkg::CNT_W-1:0] msg_len = '0;
	logic                      saw_bad = 1'b0;
	logic                      saw_ctrl = 1'b0;
	logic [utv_pkg::CFG_W-1:0] len_limit = utv_pkg::CFG_RST;

	verdict_t   verdicts_due[$];
	logic [7:0] msg_q[$];
	int         errors = 0;
	int         items_sent = 0;
	// Pacing knobs: quiet flags switch the random gaps off, long_hold asks
	// the receiver for one long stall
	bit         send_quiet = 1'b0;
	bit         recv_quiet = 1'b0;
	int         long_hold = 0;

	utf8_text_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_bytes_we (max_bytes_we),
		.max_bytes    (max_bytes),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.done_res     (done_res),
		.accepted     (accepted),
		.reason       (reason)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		errors++;
		$display("%0t ERROR %s: got %0h expected %0h", $time, what, got, want);
	endtask

	// Append one byte to the message under construction
	task automatic append_byte(input logic [7:0] b);
		msg_q.insert(msg_q.size(), b);
	endtask

	// Queue one expected result beat
	task automatic append_verdict(input verdict_t v);
		verdicts_due.insert(verdicts_due.size(), v);
	endtask

	// Advance the mirrored decoder by one accepted beat and queue the result
	task automatic predict_verdict(input logic [7:0] b, input logic hb, input logic lst);
		logic       bad;
		logic [2:0] why;
		if (hb) begin
			if (msg_len != utv_pkg::CNT_SAT)
				msg_len++;
			if (b < utv_pkg::B_SPACE && b != utv_pkg::B_TAB && b != utv_pkg::B_LF)
				saw_ctrl = 1'b1;
			if (dec_pending != 2'd0) begin
				// Continuation expected: check the tag and any second-byte bound
				bad = (b & utv_pkg::B_CONT_MSK) != utv_pkg::B_CONT_TAG;
				case (dec_rule)
					utv_pkg::RULE_GE_A0: bad = bad || (b < utv_pkg::B_A0);
					utv_pkg::RULE_LT_A0: bad = bad || (b >= utv_pkg::B_A0);
					utv_pkg::RULE_GE_90: bad = bad || (b < utv_pkg::B_90);
					utv_pkg::RULE_LT_90: bad = bad || (b >= utv_pkg::B_90);
					default: ;
				endcase
				dec_rule = utv_pkg::RULE_NONE;
				if (bad) begin
					saw_bad = 1'b1;
					dec_pending = 2'd0;
				end else begin
					dec_pending--;
				end
			end else if (b <= utv_pkg::B_ASCII_HI) begin
				// plain ASCII, nothing to track
			end else if (b >= utv_pkg::B_L2_LO && b <= utv_pkg::B_L2_HI) begin
				dec_pending = 2'd1;
				dec_rule = utv_pkg::RULE_NONE;
			end else if (b >= utv_pkg::B_L3_LO && b <= utv_pkg::B_L3_HI) begin
				dec_pending = 2'd2;
				dec_rule = (b == utv_pkg::B_L3_LO) ? utv_pkg::RULE_GE_A0 :
					(b == utv_pkg::B_SURR) ? utv_pkg::RULE_LT_A0 : utv_pkg::RULE_NONE;
			end else if (b >= utv_pkg::B_L4_LO && b <= utv_pkg::B_L4_HI) begin
				dec_pending = 2'd3;
				dec_rule = (b == utv_pkg::B_L4_LO) ? utv_pkg::RULE_GE_90 :
					(b == utv_pkg::B_L4_HI) ? utv_pkg::RULE_LT_90 : utv_pkg::RULE_NONE;
			end else begin
				// C0, C1, F5..FF and stray continuations
				saw_bad = 1'b1;
			end
		end
		if (!lst) begin
			append_verdict('{done: 1'b0, ok: 1'b0, why: utv_pkg::REASON_OK});
		end else begin
			// Priority: empty, too long, bad encoding (incl. truncation), control
			if (msg_len == '0)
				why = utv_pkg::REASON_EMPTY;
			else if (msg_len > {1'b0, len_limit})
				why = utv_pkg::REASON_LONG;
			else if (saw_bad || dec_pending != 2'd0)
				why = utv_pkg::REASON_BAD;
			else if (saw_ctrl)
				why = utv_pkg::REASON_CTRL;
			else
				why = utv_pkg::REASON_OK;
			append_verdict('{done: 1'b1, ok: (why == utv_pkg::REASON_OK), why: why});
			dec_pending = 2'd0;
			dec_rule = utv_pkg::RULE_NONE;
			msg_len = '0;
			saw_bad = 1'b0;
			saw_ctrl = 1'b0;
		end
	endtask

	// Offer one beat after a random gap and hold it until the block takes it.
	// Call right after a rising edge.
	task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		has_byte  <= hb;
		last      <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_verdict(b, hb, lst);
		if (hb || lst)
			items_sent++;
	endtask

	// Send msg_q as one message; optionally close it with a bare end marker
	// and sprinkle bare items that are not last
	task automatic send_msg(input bit end_bare, input int bare_pct);
		int n;
		n = msg_q.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < bare_pct)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(msg_q[i], 1'b1, !end_bare && i == n - 1);
		end
		if (n == 0 || end_bare)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	// Send up to four bytes, most significant first, as one message
	task automatic send_word(input logic [31:0] w, input int n);
		msg_q.delete();
		for (int i = 0; i < n; i++)
			append_byte(w[31 - 8 * i -: 8]);
		send_msg(1'b0, 0);
	endtask

	// Drop valid and wait until every expected result beat has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_limit(input logic [utv_pkg::CFG_W-1:0] v);
		wait_idle();
		max_bytes_we <= 1'b1;
		max_bytes    <= v;
		@(posedge clk);
		max_bytes_we <= 1'b0;
		len_limit = v;
	endtask

	// Append one multi-byte character; now and then break its second-byte bound
	task automatic push_multibyte(input int len);
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		case (len)
			2: begin
				lead = 8'($urandom_range(utv_pkg::B_L2_LO, utv_pkg::B_L2_HI));
				lo = 8'h80;
				hi = 8'hBF;
			end
			3: begin
				case ($urandom_range(0, 3))
					0: lead = utv_pkg::B_L3_LO;
					1: lead = utv_pkg::B_SURR;
					default: lead = 8'($urandom_range(utv_pkg::B_L3_LO, utv_pkg::B_L3_HI));
				endcase
				lo = (lead == utv_pkg::B_L3_LO) ? utv_pkg::B_A0 : 8'h80;
				hi = (lead == utv_pkg::B_SURR) ? 8'h9F : 8'hBF;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: lead = utv_pkg::B_L4_LO;
					1: lead = utv_pkg::B_L4_HI;
					default: lead = 8'($urandom_range(utv_pkg::B_L4_LO, utv_pkg::B_L4_HI));
				endcase
				lo = (lead == utv_pkg::B_L4_LO) ? utv_pkg::B_90 : 8'h80;
				hi = (lead == utv_pkg::B_L4_HI) ? 8'h8F : 8'hBF;
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			lo = 8'h80;
			hi = 8'hBF;
		end
		append_byte(lead);
		append_byte(8'($urandom_range(lo, hi)));
		for (int i = 2; i < len; i++)
			append_byte(8'($urandom_range(8'h80, 8'hBF)));
	endtask

	// Build a message of mostly well-formed text with some noise mixed in
	task automatic gen_text(input int nchars);
		int kind;
		msg_q.delete();
		repeat (nchars) begin
			kind = $urandom_range(0, 99);
			if (kind < 30)
				append_byte(8'($urandom_range(utv_pkg::B_SPACE, utv_pkg::B_ASCII_HI)));
			else if (kind < 35)
				append_byte($urandom_range(0, 1) ? utv_pkg::B_TAB : utv_pkg::B_LF);
			else if (kind < 38)
				append_byte(8'($urandom_range(0, 8'h1F)));
			else if (kind < 52)
				push_multibyte(2);
			else if (kind < 72)
				push_multibyte(3);
			else if (kind < 88)
				push_multibyte(4);
			else if (kind < 94)
				append_byte(8'($urandom_range(0, 255)));
			else begin
				// cut a character short
				push_multibyte($urandom_range(2, 4));
				void'(msg_q.pop_back());
			end
		end
	endtask

	// Bare items: an end marker alone is an empty message, and a bare item
	// that is not last changes nothing whatever its byte
	task automatic test_bare_items();
		send_beat(8'h41, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h42, 1'b1, 1'b0);
		send_beat(8'hC3, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
	endtask

	// Encoding edges: each length at both ends, overlongs, surrogates,
	// above U+10FFFF, illegal leads, strays, truncation and recovery
	task automatic test_encodings();
		send_word(32'hC2800000, 2);
		send_word(32'hDFBF0000, 2);
		send_word(32'hE0A08000, 3);
		send_word(32'hE09FBF00, 3);
		send_word(32'hED9FBF00, 3);
		send_word(32'hEDA08000, 3);
		send_word(32'hEFBFBF00, 3);
		send_word(32'hF0908080, 4);
		send_word(32'hF08FBFBF, 4);
		send_word(32'hF48FBFBF, 4);
		send_word(32'hF4908080, 4);
		send_word(32'hC0800000, 2);
		send_word(32'hC1BF0000, 2);
		send_word(32'hF5808080, 4);
		send_word(32'hFF000000, 1);
		send_word(32'h80000000, 1);
		send_word(32'hE2820000, 2);
		send_word(32'hC2410000, 2);
		send_word(32'hE080E282, 4);
	endtask

	// Control bytes: forbidden below space except tab and newline; DEL is fine;
	// bad encoding outranks a control byte
	task automatic test_controls();
		send_word(32'h00000000, 1);
		send_word(32'h1F000000, 1);
		send_word(32'h090A7F20, 4);
		send_word(32'h4101C000, 3);
	endtask

	// Length limit at its low end and the reason priority around it
	task automatic test_limits();
		set_limit(16'd0);
		send_word(32'h41000000, 1);
		send_beat(8'h41, 1'b0, 1'b1);
		set_limit(16'd1);
		send_word(32'h41000000, 1);
		send_word(32'h41420000, 2);
		send_word(32'hC0000000, 2);
		send_word(32'h00000000, 1);
		send_word(32'hC0000000, 1);
		set_limit(16'd2);
		send_word(32'hE2820000, 2);
	endtask

	// Mid-size limit: a message right at it, then one byte over it
	task automatic test_long_messages();
		set_limit(16'd48);
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		for (int i = 0; i < 48; i++)
			send_beat(8'($urandom_range(utv_pkg::B_SPACE, 8'h7E)), 1'b1, i == 47);
		for (int i = 0; i < 49; i++)
			send_beat(8'($urandom_range(utv_pkg::B_SPACE, 8'h7E)), 1'b1, i == 48);
		send_word(32'h41000000, 1);
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	// Hold the receiver off for a long stretch while beats keep coming,
	// so the block fills and stalls its input
	task automatic test_backpressure();
		set_limit(utv_pkg::CFG_RST);
		send_quiet = 1'b1;
		long_hold = 120;
		repeat (8) begin
			gen_text($urandom_range(2, 6));
			send_msg(1'b0, 0);
		end
		send_quiet = 1'b0;
	endtask

	// Random text across several limit settings, one phase without gaps
	task automatic test_random_text();
		logic [utv_pkg::CFG_W-1:0] limits[6];
		int start;
		int phase_start;
		int phase;
		limits[0] = 16'($urandom_range(2, 24));
		limits[1] = 16'hFFFF;
		limits[2] = 16'd0;
		limits[3] = 16'($urandom_range(4, 16));
		limits[4] = 16'd1;
		limits[5] = 16'($urandom_range(0, 16'hFFFF));
		start = items_sent;
		phase = 0;
		while (items_sent - start < 400) begin
			set_limit(limits[phase % 6]);
			send_quiet = (phase == 3);
			recv_quiet = (phase == 3);
			phase_start = items_sent;
			while (items_sent - phase_start < 70) begin
				gen_text(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10));
				send_msg($urandom_range(0, 6) == 0, 5);
			end
			phase++;
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	// Receiver pacing: stall a random number of cycles before each result
	// beat, or once for the long stretch the pressure test asks for
	initial begin : result_pacing
		int hold;
		forever begin
			if (long_hold != 0) begin
				hold = long_hold;
				long_hold = 0;
			end else begin
				hold = recv_quiet ? 0 : $urandom_range(0, 6);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	// Compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				flag_mismatch("unexpected result beat", {5'd0, reason}, 8'h00);
			end else begin
				want = verdicts_due.pop_front();
				if (done_res !== want.done)
					flag_mismatch("done_res", {7'd0, done_res}, {7'd0, want.done});
				if (accepted !== want.ok)
					flag_mismatch("accepted", {7'd0, accepted}, {7'd0, want.ok});
				if (reason !== want.why)
					flag_mismatch("reason", {5'd0, reason}, {5'd0, want.why});
			end
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("FAIL utf8_text_validator");
		$finish;
	end

	initial begin : main_sequence
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bare_items();
		test_encodings();
		test_controls();
		test_limits();
		test_long_messages();
		test_backpressure();
		test_random_text();
		wait_idle();
		if (errors == 0)
			$display("PASS utf8_text_validator");
		else
			$display("FAIL utf8_text_validator");
		$finish;
	end

endmodule

/* files.f */
src/utv_pkg.sv
src/utv_step.sv
src/utf8_text_validator.sv
test/tb_utf8_text_validator.sv
